@@ design/rmte_pkg.sv @@
// ----------------------------------------------------------------------------
// rmte_pkg
// Shared types and constants of the rotation-matrix to Euler-angle converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmte_pkg;

   // Fixed-point constants.
   localparam int ATAN_ENTRIES = 24;
   localparam int SQRT_BITS    = 16;
   localparam int PRESCALE_SH  = 12;
   localparam logic signed [27:0] ANG_PI  = 28'sd52707179;
   localparam logic signed [16:0] OUT_MAX = 17'sd25736;

   // Register map: index of the threshold register.
   localparam logic REG_THRESHOLD = 1'b0;

   // Arctangent table, round(atan(2^-i) * 2^24).
   localparam logic signed [27:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
      28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
      28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
   };

   // Matrix entries, squares and square-root state of the front stages.
   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r20;
      logic signed [15:0] r21;
      logic signed [15:0] r22;
      logic [31:0]        sq_a;
      logic [31:0]        sq_b;
      logic [31:0]        sumsq;
      logic [19:0]        rem;
      logic [15:0]        root;
   } front_type;

   // One CORDIC lane.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [27:0] z;
      logic               byp;
   } lane_type;

   typedef struct packed {
      lane_type [2:0] lane;
      logic           sing;
   } back_type;

endpackage

`default_nettype wire

@@ design/rotation_matrix_to_euler_angles_top.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_top
// Z-Y-X Euler angles from a Q2.14 rotation matrix, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): seven Q2.14 matrix entries, one transfer per
//    cycle at most. Response channel (rsp_*): three Q3.13 angles and the
//    singular flag, exactly one response per request, in order.
//  - The pipeline has CORDIC_STEPS + 20 register stages: two for the squares
//    and their sum, sixteen for the bit-per-stage integer square root, one
//    for the singular decision and quadrant fold, one per CORDIC iteration,
//    one for rounding.
//  - Throughput is one item per cycle while the receiver does not stall; the
//    three arctangents run in parallel lanes of the same pipeline stages.
//  - When the receiver stalls, each stage holds while the stage after it is
//    full and held; empty stages keep filling, so bubbles are squeezed out.
//  - Reset empties the pipeline and sets the threshold register to 1.
//  - The threshold register sits at byte address 0 of the csr_ port and is
//    to be written only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_euler_angles_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [15:0]  req_r00,
   input  wire logic signed [15:0]  req_r10,
   input  wire logic signed [15:0]  req_r11,
   input  wire logic signed [15:0]  req_r12,
   input  wire logic signed [15:0]  req_r20,
   input  wire logic signed [15:0]  req_r21,
   input  wire logic signed [15:0]  req_r22,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_angle_x,
   output logic signed [15:0]       rsp_angle_y,
   output logic signed [15:0]       rsp_angle_z,
   output logic                     rsp_singular,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [2:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import rmte_pkg::*;

   localparam int NF = SQRT_BITS + 2;
   localparam int NB = CORDIC_STEPS + 1;
   localparam int NS = NF + NB + 1;

   logic [NS-1:0] valid_ff;
   logic [NS:0]   ready;
   front_type     front_ff [NF];
   back_type      back_ff  [NB];
   logic [14:0]   thresh_ff;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_THRESHOLD) ? {17'd0, thresh_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= 15'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_THRESHOLD) begin
         thresh_ff <= csr_pwdata[14:0];
      end
   end

   // Stage handshake: a stage loads when it is empty or its content moves on.
   assign ready[NS] = !rsp_stall;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_ready
         assign ready[k] = !valid_ff[k] || ready[k+1];
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (ready[k]) begin
               valid_ff[k] <= (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   endgenerate

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NS-1];

   // Stage 0: register the entries and form the two squares.
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         front_ff[0].r00   <= req_r00;
         front_ff[0].r10   <= req_r10;
         front_ff[0].r11   <= req_r11;
         front_ff[0].r12   <= req_r12;
         front_ff[0].r20   <= req_r20;
         front_ff[0].r21   <= req_r21;
         front_ff[0].r22   <= req_r22;
         front_ff[0].sq_a  <= 32'(req_r00 * req_r00);
         front_ff[0].sq_b  <= 32'(req_r10 * req_r10);
         front_ff[0].sumsq <= 32'd0;
         front_ff[0].rem   <= 20'd0;
         front_ff[0].root  <= 16'd0;
      end
   end

   // Stage 1: sum of squares.
   front_type sum_in;
   always_comb begin
      sum_in       = front_ff[0];
      sum_in.sumsq = front_ff[0].sq_a + front_ff[0].sq_b;
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         front_ff[1] <= sum_in;
      end
   end

   // Square root, one result bit per stage, most significant first.
   generate
      for (k = 0; k < SQRT_BITS; k++) begin : g_sqrt
         localparam int B = SQRT_BITS - 1 - k;
         logic [19:0] rem_sh;
         logic [19:0] trial;
         front_type   step_in;
         assign rem_sh = {front_ff[k+1].rem[17:0], front_ff[k+1].sumsq[2*B +: 2]};
         assign trial  = {2'b00, front_ff[k+1].root, 2'b01};
         always_comb begin
            step_in = front_ff[k+1];
            if (rem_sh >= trial) begin
               step_in.rem  = rem_sh - trial;
               step_in.root = {front_ff[k+1].root[14:0], 1'b1};
            end else begin
               step_in.rem  = rem_sh;
               step_in.root = {front_ff[k+1].root[14:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (ready[k+2]) begin
               front_ff[k+2] <= step_in;
            end
         end
      end
   endgenerate

   // Singular decision, operand choice and quadrant fold.
   logic              sing;
   logic signed [17:0] op_y [3];
   logic signed [17:0] op_x [3];
   lane_type          fold [3];

   always_comb begin
      sing    = {1'b0, front_ff[NF-1].root} < {2'b00, thresh_ff};
      op_y[0] = sing ? -18'(front_ff[NF-1].r12) : 18'(front_ff[NF-1].r21);
      op_x[0] = sing ? 18'(front_ff[NF-1].r11) : 18'(front_ff[NF-1].r22);
      op_y[1] = -18'(front_ff[NF-1].r20);
      op_x[1] = 18'($signed({2'b00, front_ff[NF-1].root}));
      op_y[2] = 18'(front_ff[NF-1].r10);
      op_x[2] = 18'(front_ff[NF-1].r00);
      for (int l = 0; l < 3; l++) begin
         fold[l].byp = (op_y[l] == 18'sd0);
         if (op_x[l] < 0) begin
            fold[l].x = 32'(-op_x[l]) <<< PRESCALE_SH;
            fold[l].y = 32'(-op_y[l]) <<< PRESCALE_SH;
            fold[l].z = (op_y[l] >= 0) ? ANG_PI : -ANG_PI;
         end else begin
            fold[l].x = 32'(op_x[l]) <<< PRESCALE_SH;
            fold[l].y = 32'(op_y[l]) <<< PRESCALE_SH;
            fold[l].z = 28'sd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[NF]) begin
         back_ff[0].sing <= sing;
         for (int l = 0; l < 3; l++) begin
            back_ff[0].lane[l] <= fold[l];
         end
      end
   end

   // CORDIC vectoring iterations, one per stage, three lanes side by side.
   generate
      for (k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
         back_type nxt;
         always_comb begin
            nxt = back_ff[k];
            for (int l = 0; l < 3; l++) begin
               if (!back_ff[k].lane[l].byp && k < ATAN_ENTRIES) begin
                  if (back_ff[k].lane[l].y >= 0) begin
                     nxt.lane[l].x = back_ff[k].lane[l].x + (back_ff[k].lane[l].y >>> k);
                     nxt.lane[l].y = back_ff[k].lane[l].y - (back_ff[k].lane[l].x >>> k);
                     nxt.lane[l].z = back_ff[k].lane[l].z + ATAN_TABLE[k % ATAN_ENTRIES];
                  end else begin
                     nxt.lane[l].x = back_ff[k].lane[l].x - (back_ff[k].lane[l].y >>> k);
                     nxt.lane[l].y = back_ff[k].lane[l].y + (back_ff[k].lane[l].x >>> k);
                     nxt.lane[l].z = back_ff[k].lane[l].z - ATAN_TABLE[k % ATAN_ENTRIES];
                  end
               end
            end
         end
         always_ff @(posedge clock) begin
            if (ready[NF+1+k]) begin
               back_ff[k+1] <= nxt;
            end
         end
      end
   endgenerate

   // Rounding to Q3.13 with saturation; the output register.
   logic signed [16:0] q   [3];
   logic signed [15:0] ang [3];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         q[l] = 17'((back_ff[NB-1].lane[l].z + 28'sd1024) >>> 11);
         if (q[l] > OUT_MAX) begin
            ang[l] = 16'(OUT_MAX);
         end else if (q[l] < -OUT_MAX) begin
            ang[l] = 16'(-OUT_MAX);
         end else begin
            ang[l] = q[l][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[NS-1]) begin
         rsp_angle_x  <= ang[0];
         rsp_angle_y  <= ang[1];
         rsp_angle_z  <= back_ff[NB-1].sing ? 16'sd0 : ang[2];
         rsp_singular <= back_ff[NB-1].sing;
      end
   end

endmodule

`default_nettype wire

@@ design/rmte_checker.sv @@
// ----------------------------------------------------------------------------
// rmte_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmte_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_angle_x,
   input wire logic signed [15:0] rsp_angle_y,
   input wire logic signed [15:0] rsp_angle_z,
   input wire logic               rsp_singular
);
   import rmte_pkg::*;

   // The pipeline is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A gimbal-locked response carries no z rotation.
   a_sing_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_angle_z == 16'sd0)
      else $error("z angle not zero on singular response");

   // All angles stay within the saturation bounds.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_x <= 16'(OUT_MAX)) && (rsp_angle_x >= -16'(OUT_MAX))
                 && (rsp_angle_y <= 16'(OUT_MAX)) && (rsp_angle_y >= -16'(OUT_MAX))
                 && (rsp_angle_z <= 16'(OUT_MAX)) && (rsp_angle_z >= -16'(OUT_MAX)))
      else $error("angle out of range");

   // A stalled response stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_angle_y))
      else $error("stalled response dropped");

endmodule

bind rotation_matrix_to_euler_angles_top rmte_checker u_rmte_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_angle_x (rsp_angle_x),
   .rsp_angle_y (rsp_angle_y),
   .rsp_angle_z (rsp_angle_z),
   .rsp_singular(rsp_singular)
);

`default_nettype wire
